/* hw/rtl/fep_pkg.sv */
// Shared constants, payload types and the colour palette of the fire effect propagator.
package fep_pkg;

	localparam int unsigned COLS   = 160;
	localparam int unsigned ROWS   = 120;
	localparam int unsigned CELLS  = COLS * ROWS;
	localparam int unsigned ADDR_W = $clog2(CELLS);

	localparam int unsigned IDX_W   = 15;
	localparam int unsigned LEVEL_W = 6;
	localparam int unsigned DECAY_W = 2;

	localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(36);
	localparam logic [DECAY_W-1:0] MAX_DECAY = DECAY_W'(2);

	localparam logic OP_PROPAGATE = 1'b0;
	localparam logic OP_READ      = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUSY
	} fep_state_t;

	typedef struct packed {
		logic               operation;
		logic [DECAY_W-1:0] decay;
		logic [IDX_W-1:0]   read_index;
	} fep_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]   cell_index;
		logic [LEVEL_W-1:0] intensity;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               wrote;
		logic               frame_end;
	} fep_out_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} fep_rgb_t;

	function automatic fep_rgb_t palette(input logic [LEVEL_W-1:0] level);
		fep_rgb_t c;
		case (level)
			6'd0:  c = '{8'd7,   8'd7,   8'd7};
			6'd1:  c = '{8'd31,  8'd7,   8'd7};
			6'd2:  c = '{8'd47,  8'd15,  8'd7};
			6'd3:  c = '{8'd71,  8'd15,  8'd7};
			6'd4:  c = '{8'd87,  8'd23,  8'd7};
			6'd5:  c = '{8'd103, 8'd31,  8'd7};
			6'd6:  c = '{8'd119, 8'd31,  8'd7};
			6'd7:  c = '{8'd143, 8'd39,  8'd7};
			6'd8:  c = '{8'd159, 8'd47,  8'd7};
			6'd9:  c = '{8'd175, 8'd63,  8'd7};
			6'd10: c = '{8'd191, 8'd71,  8'd7};
			6'd11: c = '{8'd199, 8'd71,  8'd7};
			6'd12: c = '{8'd223, 8'd79,  8'd7};
			6'd13: c = '{8'd223, 8'd87,  8'd7};
			6'd14: c = '{8'd223, 8'd87,  8'd7};
			6'd15: c = '{8'd215, 8'd95,  8'd7};
			6'd16: c = '{8'd215, 8'd95,  8'd7};
			6'd17: c = '{8'd215, 8'd103, 8'd15};
			6'd18: c = '{8'd207, 8'd111, 8'd15};
			6'd19: c = '{8'd207, 8'd119, 8'd15};
			6'd20: c = '{8'd207, 8'd127, 8'd15};
			6'd21: c = '{8'd207, 8'd135, 8'd23};
			6'd22: c = '{8'd199, 8'd135, 8'd23};
			6'd23: c = '{8'd199, 8'd143, 8'd23};
			6'd24: c = '{8'd199, 8'd151, 8'd31};
			6'd25: c = '{8'd191, 8'd159, 8'd31};
			6'd26: c = '{8'd191, 8'd159, 8'd31};
			6'd27: c = '{8'd191, 8'd167, 8'd39};
			6'd28: c = '{8'd191, 8'd167, 8'd39};
			6'd29: c = '{8'd191, 8'd175, 8'd47};
			6'd30: c = '{8'd183, 8'd175, 8'd47};
			6'd31: c = '{8'd183, 8'd183, 8'd47};
			6'd32: c = '{8'd183, 8'd183, 8'd55};
			6'd33: c = '{8'd207, 8'd207, 8'd111};
			6'd34: c = '{8'd223, 8'd223, 8'd159};
			6'd35: c = '{8'd239, 8'd239, 8'd199};
			// Intensity 36 and anything above it saturate to white.
			default: c = '{8'd255, 8'd255, 8'd255};
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/fep_if.sv */
// Valid/ready channel interfaces for the request and response items.
interface fep_in_if;
	logic             valid;
	logic             ready;
	fep_pkg::fep_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fep_out_if;
	logic              valid;
	logic              ready;
	fep_pkg::fep_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/fire_effect_propagator.sv */
// Fire effect propagator: intensity grid in on-chip memory with a sweep cursor.
//
// The req channel takes one item: a propagate step at the internal cursor or a
// read of one cell. The rsp channel returns exactly one item for each request:
// the cell index written or read, its intensity, its palette colour and flags.
// Both channels use valid/ready; an item moves when both are high.
//
// An accepted request that has a cell to read loads it from the grid memory
// into the read data register as it is taken; the result then passes into
// the output register once the rsp side is free. The block handles one item
// at a time: it takes no new request until the last one has finished and
// its result is in the output register.
//
// After reset the memory is filled with the top intensity, one cell per cycle,
// through all COLS*ROWS cells (19200 at 160 by 120); req.ready stays low
// throughout. The sweep cursor starts at cell zero.
//
// A stalled rsp side holds the result in the output register; a new request
// is still taken, and its write-back waits until the register is free.
module fire_effect_propagator (
	input logic       clk,
	input logic       arst_n,
	fep_in_if.sink    req,
	fep_out_if.source rsp
);
	import fep_pkg::*;

	fep_state_t state_q, state_d;

	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  cursor_q;
	logic               op_q;
	logic [DECAY_W-1:0] decay_q;
	logic [IDX_W-1:0]   idx_q;
	logic               in_range_q;
	logic               last_q;
	logic [LEVEL_W-1:0] rd_data_q;
	fep_out_t           out_q;
	logic               out_valid_q;

	logic [LEVEL_W-1:0] mem [CELLS];

	logic               accept;
	logic               has_below;
	logic               ridx_ok;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_en;
	logic [DECAY_W-1:0] decay_sat;
	logic               done;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [LEVEL_W-1:0] wr_data;
	logic [LEVEL_W-1:0] new_level;
	logic [IDX_W-1:0]   pos;
	logic [LEVEL_W-1:0] res_level;
	fep_rgb_t           res_rgb;
	fep_out_t           result;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign has_below = cursor_q < ADDR_W'(CELLS - COLS);
	assign ridx_ok   = req.data.read_index < IDX_W'(CELLS);
	assign rd_addr   = (req.data.operation == OP_READ)
		? ADDR_W'(req.data.read_index) : ADDR_W'(cursor_q + ADDR_W'(COLS));
	assign rd_en     = accept && ((req.data.operation == OP_READ) ? ridx_ok : has_below);
	assign decay_sat = (req.data.decay > MAX_DECAY) ? MAX_DECAY : req.data.decay;

	assign done = (state_q == ST_BUSY) && (!out_valid_q || rsp.ready);

	// Propagate arithmetic on the cell read below the cursor.
	assign new_level = (rd_data_q >= LEVEL_W'(decay_q)) ? rd_data_q - LEVEL_W'(decay_q) : '0;
	assign pos       = (idx_q >= IDX_W'(decay_q)) ? idx_q - IDX_W'(decay_q) : '0;
	assign res_level = (op_q == OP_READ) ? (in_range_q ? rd_data_q : '0) : new_level;
	assign res_rgb   = palette(res_level);

	always_comb begin
		result = '0;
		if (op_q == OP_READ) begin
			result.cell_index = idx_q;
			result.intensity  = res_level;
			result.red        = res_rgb.red;
			result.green      = res_rgb.green;
			result.blue       = res_rgb.blue;
		end else if (in_range_q) begin
			result.cell_index = pos;
			result.intensity  = res_level;
			result.red        = res_rgb.red;
			result.green      = res_rgb.green;
			result.blue       = res_rgb.blue;
			result.wrote      = 1'b1;
			result.frame_end  = last_q;
		end else begin
			// Bottom row: nothing is written and the colour stays black.
			result.cell_index = idx_q;
			result.frame_end  = last_q;
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = TOP_LEVEL;
		end else begin
			wr_en   = done && (op_q == OP_PROPAGATE) && in_range_q;
			wr_addr = ADDR_W'(pos);
			wr_data = new_level;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(CELLS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept)
					state_d = ST_BUSY;
			end
			ST_BUSY: begin
				if (done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (done && (op_q == OP_PROPAGATE))
				cursor_q <= last_q ? '0 : cursor_q + 1'b1;
			if (done)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.data.operation;
			decay_q    <= decay_sat;
			idx_q      <= (req.data.operation == OP_READ)
				? req.data.read_index : IDX_W'(cursor_q);
			in_range_q <= (req.data.operation == OP_READ) ? ridx_ok : has_below;
			last_q     <= cursor_q == ADDR_W'(CELLS - 1);
		end
		if (done)
			out_q <= result;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

/* hw/rtl/fep_chk.sv */
// Port-level assertions for the fire effect propagator, bound to the top level.
module fep_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input fep_pkg::fep_out_t rsp_data
);
	import fep_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response item dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("response item changed while stalled");

	// Only one item is in flight: the request side closes right after acceptance.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another item is in flight");

	// With the output register empty, the result goes through the read data register into the output register unstalled.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
		else $error("result did not appear two cycles after acceptance");

endmodule

bind fire_effect_propagator fep_chk u_fep_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

/* sim/fire_effect_propagator_test.sv */
// Self-checking testbench for the fire effect propagator: directed table, then random traffic.
module fire_effect_propagator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fep_pkg::*;

	typedef struct packed {
		fep_in_t  stim;
		logic     known;
		fep_out_t want;
	} table_row_t;

	localparam int unsigned DIRECTED_ROWS = 16;
	localparam int unsigned DRAIN_LIMIT   = 100000;

	// Rows with known = 1 carry a fixed result, worked out from the grid as reset and the earlier rows leave it.
	localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{OP_READ, 2'd0, 15'd0}, 1'b1,
			'{15'd0, 6'd36, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}},
		'{'{OP_READ, 2'd3, 15'd19199}, 1'b1,
			'{15'd19199, 6'd36, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}},
		'{'{OP_READ, 2'd0, 15'd19200}, 1'b1,
			'{15'd19200, 6'd0, 8'd7, 8'd7, 8'd7, 1'b0, 1'b0}},
		'{'{OP_READ, 2'd2, 15'd32767}, 1'b1,
			'{15'd32767, 6'd0, 8'd7, 8'd7, 8'd7, 1'b0, 1'b0}},
		'{'{OP_PROPAGATE, 2'd0, 15'd0}, 1'b1,
			'{15'd0, 6'd36, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0}},
		'{'{OP_PROPAGATE, 2'd1, 15'd0}, 1'b1,
			'{15'd0, 6'd35, 8'd239, 8'd239, 8'd199, 1'b1, 1'b0}},
		'{'{OP_PROPAGATE, 2'd2, 15'd0}, 1'b1,
			'{15'd0, 6'd34, 8'd223, 8'd223, 8'd159, 1'b1, 1'b0}},
		'{'{OP_PROPAGATE, 2'd3, 15'd0}, 1'b1,
			'{15'd1, 6'd34, 8'd223, 8'd223, 8'd159, 1'b1, 1'b0}},
		'{'{OP_READ, 2'd0, 15'd0}, 1'b1,
			'{15'd0, 6'd34, 8'd223, 8'd223, 8'd159, 1'b0, 1'b0}},
		'{'{OP_READ, 2'd1, 15'd1}, 1'b1,
			'{15'd1, 6'd34, 8'd223, 8'd223, 8'd159, 1'b0, 1'b0}},
		'{'{OP_READ, 2'd0, 15'd2}, 1'b1,
			'{15'd2, 6'd36, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}},
		'{'{OP_READ, 2'd0, 15'd160}, 1'b0, '0},
		'{'{OP_PROPAGATE, 2'd2, 15'd32767}, 1'b0, '0},
		'{'{OP_PROPAGATE, 2'd1, 15'd21845}, 1'b0, '0},
		'{'{OP_READ, 2'd3, 15'd2}, 1'b0, '0},
		'{'{OP_READ, 2'd0, 15'd16384}, 1'b1,
			'{15'd16384, 6'd36, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0}}
	};

	localparam logic [23:0] COLOUR_OF [37] = '{
		{8'd7, 8'd7, 8'd7},       {8'd31, 8'd7, 8'd7},      {8'd47, 8'd15, 8'd7},
		{8'd71, 8'd15, 8'd7},     {8'd87, 8'd23, 8'd7},     {8'd103, 8'd31, 8'd7},
		{8'd119, 8'd31, 8'd7},    {8'd143, 8'd39, 8'd7},    {8'd159, 8'd47, 8'd7},
		{8'd175, 8'd63, 8'd7},    {8'd191, 8'd71, 8'd7},    {8'd199, 8'd71, 8'd7},
		{8'd223, 8'd79, 8'd7},    {8'd223, 8'd87, 8'd7},    {8'd223, 8'd87, 8'd7},
		{8'd215, 8'd95, 8'd7},    {8'd215, 8'd95, 8'd7},    {8'd215, 8'd103, 8'd15},
		{8'd207, 8'd111, 8'd15},  {8'd207, 8'd119, 8'd15},  {8'd207, 8'd127, 8'd15},
		{8'd207, 8'd135, 8'd23},  {8'd199, 8'd135, 8'd23},  {8'd199, 8'd143, 8'd23},
		{8'd199, 8'd151, 8'd31},  {8'd191, 8'd159, 8'd31},  {8'd191, 8'd159, 8'd31},
		{8'd191, 8'd167, 8'd39},  {8'd191, 8'd167, 8'd39},  {8'd191, 8'd175, 8'd47},
		{8'd183, 8'd175, 8'd47},  {8'd183, 8'd183, 8'd47},  {8'd183, 8'd183, 8'd55},
		{8'd207, 8'd207, 8'd111}, {8'd223, 8'd223, 8'd159}, {8'd239, 8'd239, 8'd199},
		{8'd255, 8'd255, 8'd255}
	};

	logic clk = 1'b0;
	logic arst_n;

	fep_in_if  req ();
	fep_out_if rsp ();

	fire_effect_propagator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Own copy of the grid and the sweep position.
	logic [LEVEL_W-1:0] grid_level [CELLS];
	int unsigned        sweep_pos;

	fep_out_t    awaited_pixels [$];
	int unsigned fail_count;
	int unsigned sender_idle_pct;
	int unsigned sink_stall_pct;

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	function automatic fep_out_t fire_step(input fep_in_t it);
		fep_out_t    r;
		int unsigned dec;
		int unsigned below;
		int unsigned pos;
		int unsigned lv;
		r = '0;
		if (it.operation == OP_READ) begin
			lv = (it.read_index < CELLS) ? grid_level[it.read_index] : 0;
			r.cell_index = it.read_index;
			r.intensity = LEVEL_W'(lv);
			{r.red, r.green, r.blue} = COLOUR_OF[lv];
			return r;
		end
		dec = (it.decay > MAX_DECAY) ? MAX_DECAY : it.decay;
		below = sweep_pos + COLS;
		r.frame_end = (sweep_pos == CELLS - 1);
		if (below < CELLS) begin
			lv = (grid_level[below] >= dec) ? grid_level[below] - dec : 0;
			pos = (sweep_pos >= dec) ? sweep_pos - dec : 0;
			grid_level[pos] = LEVEL_W'(lv);
			r.cell_index = IDX_W'(pos);
			r.intensity = LEVEL_W'(lv);
			{r.red, r.green, r.blue} = COLOUR_OF[lv];
			r.wrote = 1'b1;
		end else begin
			// Bottom row: nothing lies below, so nothing is written and no colour is given.
			r.cell_index = IDX_W'(sweep_pos);
		end
		if (r.frame_end) begin
			sweep_pos = 0;
		end else begin
			sweep_pos++;
		end
		return r;
	endfunction

	function automatic fep_in_t random_request(input int unsigned read_pct);
		fep_in_t it;
		int      near;
		int      pick;
		it.operation = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_PROPAGATE;
		it.decay = DECAY_W'($urandom_range(0, 3));
		it.read_index = IDX_W'($urandom);
		if (it.operation == OP_READ) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				// Aim just around the sweep so that freshly written cells are read back.
				near = int'(sweep_pos) - 4 + int'($urandom_range(0, COLS + 8));
				if (near < 0)
					near = 0;
				it.read_index = IDX_W'(near);
			end else if (pick < 8) begin
				it.read_index = IDX_W'($urandom_range(0, CELLS - 1));
			end
		end
		return it;
	endfunction

	task automatic push_request(input fep_in_t it, input logic known, input fep_out_t want);
		fep_out_t predicted;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= it;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predicted = fire_step(it);
		awaited_pixels.push_back(known ? want : predicted);
	endtask

	always @(posedge clk) begin
		fep_out_t want;
		fep_out_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (awaited_pixels.size() == 0) begin
				note_failure($sformatf("result with nothing awaited: idx %0d lvl %0d",
					got.cell_index, got.intensity));
			end else begin
				want = awaited_pixels.pop_front();
				if (got.cell_index !== want.cell_index || got.intensity !== want.intensity ||
						got.red !== want.red || got.green !== want.green ||
						got.blue !== want.blue || got.wrote !== want.wrote ||
						got.frame_end !== want.frame_end)
					note_failure($sformatf({"mismatch: want idx %0d lvl %0d rgb %0d/%0d/%0d ",
						"wr %b fe %b, got idx %0d lvl %0d rgb %0d/%0d/%0d wr %b fe %b"},
						want.cell_index, want.intensity, want.red, want.green, want.blue,
						want.wrote, want.frame_end, got.cell_index, got.intensity,
						got.red, got.green, got.blue, got.wrote, got.frame_end));
			end
		end
		rsp.ready <= arst_n && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned phase;
		int unsigned waited;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		fail_count = 0;
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		sweep_pos = 0;
		for (int i = 0; i < CELLS; i++)
			grid_level[i] = TOP_LEVEL;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			push_request(DIRECTED[i].stim, DIRECTED[i].known, DIRECTED[i].want);

		// Full-rate traffic with neither side idling.
		repeat (300)
			push_request(random_request(10), 1'b0, '0);

		for (phase = 1; phase <= 3; phase++) begin
			sender_idle_pct = (phase == 1) ? 58 : ((phase == 3) ? 9 : 0);
			sink_stall_pct = (phase == 2) ? 58 : ((phase == 3) ? 9 : 0);
			repeat (400)
				push_request(random_request(30), 1'b0, '0);
		end
		req.valid <= 1'b0;

		waited = 0;
		while (awaited_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_pixels.size() != 0)
			note_failure($sformatf("%0d results never arrived", awaited_pixels.size()));
		repeat (16) @(posedge clk);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
